[sv/rlps_pkg.sv]
package rlps_pkg;

    // Default instruction store depth
    localparam int STORE_DEPTH_DEF = 256;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Reset value of the beat period register
    localparam logic [15:0] SPB_RESET = 16'd1000;

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    // Input opcodes
    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_START = 2'd1;
    localparam logic [1:0] OPC_TICK  = 2'd2;

    // Channel code that names no LED channel
    localparam logic [1:0] CH_NONE = 2'h3;

    // End-of-channel mark in the control byte
    localparam logic [7:0] LAST_MARK = 8'h01;

    // Instruction kinds
    localparam logic [1:0] KIND_FLASH  = 2'd0;
    localparam logic [1:0] KIND_FADE   = 2'd1;
    localparam logic [1:0] KIND_RAMPUP = 2'd2;
    localparam logic [1:0] KIND_RAMPDN = 2'd3;

    // Classified command carried through the queue
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_START,
        CMD_TICK
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] channel;
        logic [7:0] address;
        logic [7:0] ctrl;
        logic [7:0] bright;
        logic [7:0] dur;
        logic [7:0] rate;
    } item_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [7:0]  intensity;
        logic [15:0] period;
        logic        reloaded;
        logic        error;
        logic        last;
    } result_t;

endpackage

[sv/rgb_led_pattern_sequencer.sv]
// Channel   Dir  Beat contents
// s_axis    in   tuser: opcode; tdata: channel, address, control_byte, brightness,
//                duration, rate_value
// m_axis    out  tdata: out_channel, intensity, period, reloaded; tuser: error;
//                tlast: last_result
// cfg       in   cfg_we / cfg_wdata: steps_per_beat
//
// A tick that reloads its channel adds a store read and the period divider.
// A start reads the store one entry at a time until three end marks are found,
// then runs three loads; if the scan limit comes first, it emits an error result.
// Reset clears all control and channel state; store contents are undefined until
// written. A two-beat queue and the output register decouple the input and
// output sides.
module rgb_led_pattern_sequencer #(
    parameter int STORE_DEPTH = rlps_pkg::STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [15:0]                      cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // channel[1:0], address[9:2], control_byte[17:10], brightness[25:18],
    // duration[33:26], rate_value[41:34], zero fill
    input  logic [rlps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [rlps_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_channel[1:0], intensity[9:2], period[25:10], reloaded[26], zero fill
    output logic [rlps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // error[0]
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import rlps_pkg::*;

    item_t head;
    logic  head_valid;
    logic  head_pop;

    // Accept and classify
    rlps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .head_valid    (head_valid),
        .head_pop      (head_pop)
    );

    // Execute
    rlps_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .head          (head),
        .head_valid    (head_valid),
        .head_pop      (head_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sv/rlps_front.sv]
module rlps_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [rlps_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output rlps_pkg::item_t                   head,
    output logic                              head_valid,
    input  logic                              head_pop
);
    import rlps_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          q_mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    item_t          item_in;
    logic           keep;
    logic           push;
    logic           pop;

    // Classify the incoming beat
    always_comb
    begin
        item_in.channel = s_axis_tdata[1:0];
        item_in.address = s_axis_tdata[9:2];
        item_in.ctrl    = s_axis_tdata[17:10];
        item_in.bright  = s_axis_tdata[25:18];
        item_in.dur     = s_axis_tdata[33:26];
        item_in.rate    = s_axis_tdata[41:34];
        item_in.cmd     = CMD_WRITE;
        keep            = 1'b0;
        case (s_axis_tuser)
            OPC_WRITE:
            begin
                item_in.cmd = CMD_WRITE;
                keep        = 1'b1;
            end
            OPC_START:
            begin
                item_in.cmd = CMD_START;
                keep        = 1'b1;
            end
            OPC_TICK:
            begin
                item_in.cmd = CMD_TICK;
                keep        = (s_axis_tdata[1:0] != CH_NONE);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign head_valid    = (count_reg != '0);
    assign pop           = head_pop && head_valid;
    assign head          = q_mem[rd_ptr_reg];

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/rlps_div.sv]
module rlps_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import rlps_pkg::*;

    logic [8:0]  rem_reg;
    logic [15:0] q_reg;
    logic [7:0]  d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  rem_sh;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign rem_sh = {rem_reg[7:0], q_reg[15]};
    assign fits   = (rem_sh >= {1'b0, d_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, d_reg}) : rem_sh;
            q_reg   <= {q_reg[14:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 5'd16;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[sv/rlps_back.sv]
module rlps_back #(
    parameter int STORE_DEPTH = rlps_pkg::STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [15:0]                      cfg_wdata,
    input  rlps_pkg::item_t                  head,
    input  logic                             head_valid,
    output logic                             head_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rlps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import rlps_pkg::*;

    localparam int IW         = $clog2(STORE_DEPTH);
    localparam int SCAN_LIMIT = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ACT,
        ST_LD_RD,
        ST_LD_DATA,
        ST_LD_DIV,
        ST_LD_WAIT,
        ST_EMIT,
        ST_EMIT2
    } state_t;

    // Instruction store
    logic [31:0]   store_mem [STORE_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic          wr_en;

    // Channel state
    logic [7:0]  first_reg   [3];
    logic [7:0]  last_reg    [3];
    logic [7:0]  cur_reg     [3];
    logic [1:0]  mode_reg    [3];
    logic [7:0]  peak_reg    [3];
    logic [7:0]  level_reg   [3];
    logic [3:0]  step_reg    [3];
    logic        rising_reg  [3];
    logic [15:0] actions_reg [3];
    logic [15:0] period_reg  [3];
    logic [15:0] spb_reg;

    // Sequencer context
    state_t      state_reg;
    state_t      after_reg;
    logic [1:0]  ch_reg;
    logic        is_tick_reg;
    logic [7:0]  scan_i_reg;
    logic [1:0]  cnt_reg;
    logic [7:0]  f_reg [3];
    logic [7:0]  l_reg [3];
    logic [1:0]  load_n_reg;
    logic [7:0]  ld_idx_reg;
    logic [31:0] word_reg;
    logic [7:0]  lv_save_reg;
    result_t     res_reg;
    result_t     res2_reg;
    result_t     m_res_reg;
    logic        m_valid_reg;

    // Load decode
    logic [1:0]  ld_ch;
    logic [1:0]  ld_kind;
    logic [7:0]  ld_bright;
    logic [7:0]  ld_rate;
    logic [15:0] ld_prod;
    logic [2:0]  ld_k;
    logic [15:0] ld_actions;
    logic [15:0] ld_period;
    logic [7:0]  ld_peak;
    logic [7:0]  ld_level;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_q;
    logic        fin;
    logic        apply;

    // Tick action
    logic [7:0]  a_lv;
    logic [7:0]  a_pk;
    logic [7:0]  a_st;
    logic        a_rise;
    logic [7:0]  a_lv_new;
    logic [15:0] a_cnt;
    logic [8:0]  adv_sel;
    logic [7:0]  adv_idx;

    // Write and read the store
    assign wr_en  = (state_reg == ST_IDLE) && head_valid && (head.cmd == CMD_WRITE)
                    && ({24'b0, head.address} < 32'(STORE_DEPTH));
    assign wr_idx = IW'(head.address);

    always_comb
    begin
        case (state_reg)
            ST_SCAN_RD: rd_idx = IW'(scan_i_reg);
            ST_LD_RD:   rd_idx = IW'(ld_idx_reg);
            default:    rd_idx = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_idx] <= {head.rate, head.dur, head.bright, head.ctrl};
        end
        rd_data_reg <= store_mem[rd_idx];
    end

    assign head_pop = (state_reg == ST_IDLE) && head_valid;

    // Decode the loaded instruction
    assign ld_ch     = word_reg[7:6];
    assign ld_kind   = word_reg[5:4];
    assign ld_bright = word_reg[15:8];
    assign ld_rate   = (word_reg[31:24] == 8'd0) ? 8'd1 : word_reg[31:24];
    assign ld_prod   = word_reg[23:16] * ld_rate;

    always_comb
    begin
        case (ld_kind)
            KIND_FLASH:
            begin
                ld_k     = 3'd1;
                ld_peak  = ld_bright;
                ld_level = ld_bright;
            end
            KIND_FADE:
            begin
                ld_k     = 3'd5;
                ld_peak  = {ld_bright[7:4], 4'b0};
                ld_level = 8'd0;
            end
            KIND_RAMPUP:
            begin
                ld_k     = 3'd4;
                ld_peak  = {ld_bright[7:4], 4'b0};
                ld_level = 8'd0;
            end
            default:
            begin
                ld_k     = 3'd4;
                ld_peak  = {ld_bright[7:4], 4'b0};
                ld_level = {ld_bright[7:4], 4'b0};
            end
        endcase
    end

    assign ld_actions = ld_prod << ld_k;
    assign ld_period  = div_q >> ld_k;
    assign div_start  = (state_reg == ST_LD_DIV) && (ld_ch != CH_NONE);
    assign apply      = (state_reg == ST_LD_WAIT) && div_done;
    assign fin        = apply || ((state_reg == ST_LD_DIV) && (ld_ch == CH_NONE));

    rlps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (spb_reg),
        .divisor  (ld_rate),
        .done     (div_done),
        .quotient (div_q)
    );

    // Step the ticked channel's level
    always_comb
    begin
        a_lv     = level_reg[ch_reg];
        a_pk     = peak_reg[ch_reg];
        a_st     = {4'b0, step_reg[ch_reg]};
        a_rise   = rising_reg[ch_reg];
        a_lv_new = a_lv;
        case (mode_reg[ch_reg])
            KIND_FLASH:
            begin
                a_lv_new = (a_lv == a_pk) ? 8'd0 : a_pk;
            end
            KIND_FADE:
            begin
                if (a_lv >= a_pk)
                begin
                    a_rise = 1'b0;
                end
                else if (a_lv == 8'd0)
                begin
                    a_rise = 1'b1;
                end
                a_lv_new = a_rise ? (a_lv + a_st) : (a_lv - a_st);
            end
            KIND_RAMPUP:
            begin
                a_lv_new = (a_lv >= a_pk) ? 8'd0 : (a_lv + a_st);
            end
            default:
            begin
                a_lv_new = (a_lv == 8'd0) ? a_pk : (a_lv - a_st);
            end
        endcase
        a_cnt   = actions_reg[ch_reg] - 16'd1;
        adv_sel = (cur_reg[ch_reg] == last_reg[ch_reg]) ? {1'b0, first_reg[ch_reg]}
                                                        : ({1'b0, cur_reg[ch_reg]} + 9'd1);
        adv_idx = ({23'b0, adv_sel} >= 32'(SCAN_LIMIT)) ? 8'd0 : adv_sel[7:0];
    end

    // Sequencer, channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            after_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            spb_reg     <= SPB_RESET;
            ch_reg      <= '0;
            is_tick_reg <= 1'b0;
            scan_i_reg  <= '0;
            cnt_reg     <= '0;
            load_n_reg  <= '0;
            ld_idx_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i]   <= '0;
                last_reg[i]    <= '0;
                cur_reg[i]     <= '0;
                mode_reg[i]    <= KIND_FLASH;
                peak_reg[i]    <= '0;
                level_reg[i]   <= '0;
                step_reg[i]    <= '0;
                rising_reg[i]  <= 1'b0;
                actions_reg[i] <= '0;
                period_reg[i]  <= '0;
                f_reg[i]       <= '0;
                l_reg[i]       <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                spb_reg <= cfg_wdata;
            end
            // Drop the sent beat unless an emit state refills the register
            if (m_valid_reg && m_axis_tready && (state_reg != ST_EMIT)
                && (state_reg != ST_EMIT2))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        ch_reg <= head.channel;
                        case (head.cmd)
                            CMD_START:
                            begin
                                scan_i_reg <= '0;
                                cnt_reg    <= '0;
                                f_reg[0]   <= '0;
                                state_reg  <= ST_SCAN_RD;
                            end
                            CMD_TICK:
                            begin
                                state_reg <= ST_ACT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CHK;
                end

                // Look for end marks, one entry per pass
                ST_SCAN_CHK:
                begin
                    if (((rd_data_reg[7:0] & LAST_MARK) != 8'd0) && (cnt_reg == 2'd2))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            first_reg[i] <= f_reg[i];
                            cur_reg[i]   <= f_reg[i];
                            last_reg[i]  <= (i == 2) ? scan_i_reg : l_reg[i];
                        end
                        load_n_reg  <= '0;
                        ld_idx_reg  <= f_reg[0];
                        is_tick_reg <= 1'b0;
                        state_reg   <= ST_LD_RD;
                    end
                    else
                    begin
                        if ((rd_data_reg[7:0] & LAST_MARK) != 8'd0)
                        begin
                            l_reg[cnt_reg]        <= scan_i_reg;
                            f_reg[cnt_reg + 2'd1] <= scan_i_reg + 8'd1;
                            cnt_reg               <= cnt_reg + 2'd1;
                        end
                        if ({24'b0, scan_i_reg} == 32'(SCAN_LIMIT - 1))
                        begin
                            res_reg   <= '{channel: '0, intensity: '0, period: '0,
                                           reloaded: 1'b0, error: 1'b1, last: 1'b1};
                            after_reg <= ST_IDLE;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            scan_i_reg <= scan_i_reg + 8'd1;
                            state_reg  <= ST_SCAN_RD;
                        end
                    end
                end

                // Act on the ticked channel, reload when the count runs out
                ST_ACT:
                begin
                    level_reg[ch_reg]   <= a_lv_new;
                    rising_reg[ch_reg]  <= a_rise;
                    actions_reg[ch_reg] <= a_cnt;
                    lv_save_reg         <= a_lv_new;
                    if (a_cnt == 16'd0)
                    begin
                        cur_reg[ch_reg] <= adv_idx;
                        ld_idx_reg      <= adv_idx;
                        is_tick_reg     <= 1'b1;
                        state_reg       <= ST_LD_RD;
                    end
                    else
                    begin
                        res_reg   <= '{channel: ch_reg, intensity: a_lv_new,
                                       period: period_reg[ch_reg], reloaded: 1'b0,
                                       error: 1'b0, last: 1'b1};
                        after_reg <= ST_IDLE;
                        state_reg <= ST_EMIT;
                    end
                end

                ST_LD_RD:
                begin
                    state_reg <= ST_LD_DATA;
                end

                ST_LD_DATA:
                begin
                    word_reg  <= rd_data_reg;
                    state_reg <= ST_LD_DIV;
                end

                ST_LD_DIV:
                begin
                    state_reg <= (ld_ch == CH_NONE) ? ST_EMIT : ST_LD_WAIT;
                end

                ST_LD_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_res_reg   <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= after_reg;
                    end
                end

                ST_EMIT2:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_res_reg   <= res2_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Apply a finished load
            if (apply)
            begin
                mode_reg[ld_ch]    <= ld_kind;
                peak_reg[ld_ch]    <= ld_peak;
                level_reg[ld_ch]   <= ld_level;
                actions_reg[ld_ch] <= ld_actions;
                period_reg[ld_ch]  <= ld_period;
                if (ld_kind != KIND_FLASH)
                begin
                    step_reg[ld_ch] <= ld_bright[7:4];
                end
                if (ld_kind == KIND_FADE)
                begin
                    rising_reg[ld_ch] <= 1'b1;
                end
            end

            // Build the results of a finished load
            if (fin)
            begin
                if (!is_tick_reg)
                begin
                    res_reg <= '{channel: ld_ch,
                                 intensity: apply ? ld_level : 8'd0,
                                 period: apply ? ld_period : 16'd0,
                                 reloaded: apply, error: 1'b0,
                                 last: (load_n_reg == 2'd2)};
                    if (load_n_reg == 2'd2)
                    begin
                        after_reg <= ST_IDLE;
                    end
                    else
                    begin
                        after_reg  <= ST_LD_RD;
                        load_n_reg <= load_n_reg + 2'd1;
                        ld_idx_reg <= f_reg[load_n_reg + 2'd1];
                    end
                end
                else
                begin
                    res_reg  <= '{channel: ch_reg, intensity: lv_save_reg,
                                  period: (ld_ch == ch_reg) ? ld_period : period_reg[ch_reg],
                                  reloaded: (ld_ch == ch_reg), error: 1'b0,
                                  last: !(apply && (ld_ch != ch_reg))};
                    res2_reg <= '{channel: ld_ch, intensity: ld_level, period: ld_period,
                                  reloaded: 1'b1, error: 1'b0, last: 1'b1};
                    after_reg <= (apply && (ld_ch != ch_reg)) ? ST_EMIT2 : ST_IDLE;
                end
            end
        end
    end

    // Drive the result stream
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_res_reg.reloaded, m_res_reg.period,
                            m_res_reg.intensity, m_res_reg.channel};
    assign m_axis_tuser  = m_res_reg.error;
    assign m_axis_tlast  = m_res_reg.last;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import rlps_pkg::*;

    // Opcode that the block drops without any result
    localparam logic [1:0] OPC_IGNORED = 2'd3;
    localparam int         DRAIN_CYCLES = 700;
    localparam int         CYCLE_LIMIT  = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [15:0]            cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // channel[1:0], address[9:2], control_byte[17:10], brightness[25:18],
    // duration[33:26], rate_value[41:34], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // opcode[1:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // out_channel[1:0], intensity[9:2], period[25:10], reloaded[26], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // error[0]
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    rgb_led_pattern_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Pattern engine mirror
    logic [31:0] pat_mem [256];
    logic [7:0]  first_ix [3];
    logic [7:0]  last_ix [3];
    logic [7:0]  cur_ix [3];
    logic [1:0]  kind_r [3];
    logic [7:0]  peak_r [3];
    logic [7:0]  lvl_r [3];
    logic [3:0]  step_r [3];
    logic        rise_r [3];
    logic [15:0] left_r [3];
    logic [15:0] per_r [3];
    logic [15:0] spb_m;

    result_t     led_updates_q [$];
    int          err_cnt;
    int          cycles;
    bit          calm;

    typedef struct {
        logic [1:0] op;
        logic [1:0] ch;
        logic [7:0] addr;
        logic [7:0] ctl;
        logic [7:0] br;
        logic [7:0] dur;
        logic [7:0] rate;
        bit         fixed;
        result_t    exp;
    } dir_row_t;

    localparam result_t NO_RES = '{2'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0};

    dir_row_t dir_rows [] = '{
        // start on an empty store: no marks at all
        '{OPC_START, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1,
          '{2'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1}},
        '{OPC_WRITE, 2'd0, 8'd0, 8'h01, 8'hFF, 8'h01, 8'h00, 0, NO_RES},
        '{OPC_WRITE, 2'd0, 8'd1, 8'h5F, 8'hF0, 8'hFF, 8'hFF, 0, NO_RES},
        '{OPC_WRITE, 2'd0, 8'd2, 8'hF1, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_START, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        // flash at full brightness, two actions, period 1000/1 >> 1
        '{OPC_TICK, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1,
          '{2'd0, 8'd0, 16'd500, 1'b0, 1'b0, 1'b1}},
        '{OPC_TICK, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1,
          '{2'd0, 8'd255, 16'd500, 1'b1, 1'b0, 1'b1}},
        '{OPC_TICK, 2'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, NO_RES},
        '{OPC_IGNORED, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_WRITE, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, NO_RES},
        '{OPC_WRITE, 2'd0, 8'd2, 8'hA1, 8'h37, 8'h01, 8'h02, 0, NO_RES},
        '{OPC_WRITE, 2'd0, 8'd3, 8'hB0, 8'h80, 8'h01, 8'h01, 0, NO_RES},
        '{OPC_START, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd2, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd2, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd2, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES},
        '{OPC_TICK, 2'd1, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0, NO_RES}
    };

    // Load one instruction word; return the channel it targets
    function automatic logic [1:0] load_instr(logic [31:0] w);
        logic [1:0]  ch;
        logic [1:0]  kind;
        logic [15:0] rate;
        int          k;
        logic [31:0] cnt;
        ch   = w[7:6];
        kind = w[5:4];
        rate = (w[31:24] == 8'd0) ? 16'd1 : {8'd0, w[31:24]};
        if (ch == CH_NONE)
            return CH_NONE;
        if (kind == KIND_FLASH)
        begin
            peak_r[ch] = w[15:8];
            lvl_r[ch]  = w[15:8];
            k = 1;
        end
        else
        begin
            step_r[ch] = w[15:12];
            peak_r[ch] = {w[15:12], 4'd0};
            lvl_r[ch]  = (kind == KIND_RAMPDN) ? {w[15:12], 4'd0} : 8'd0;
            if (kind == KIND_FADE)
                rise_r[ch] = 1'b1;
            k = (kind == KIND_FADE) ? 5 : 4;
        end
        kind_r[ch] = kind;
        cnt = ({24'd0, w[23:16]} * {16'd0, rate}) << k;
        left_r[ch] = cnt[15:0];
        per_r[ch]  = (spb_m / rate) >> k;
        return ch;
    endfunction

    // Step a channel's intensity by one action
    function automatic void step_level(int c);
        logic [7:0] lv;
        lv = lvl_r[c];
        case (kind_r[c])
            KIND_FLASH:  lv = (lv == peak_r[c]) ? 8'd0 : peak_r[c];
            KIND_FADE:
            begin
                if (lv >= peak_r[c])
                    rise_r[c] = 1'b0;
                else if (lv == 8'd0)
                    rise_r[c] = 1'b1;
                lv = rise_r[c] ? lv + step_r[c] : lv - step_r[c];
            end
            KIND_RAMPUP: lv = (lv >= peak_r[c]) ? 8'd0 : lv + step_r[c];
            default:     lv = (lv == 8'd0) ? peak_r[c] : lv - step_r[c];
        endcase
        lvl_r[c] = lv;
    endfunction

    // Work out the LED updates caused by one accepted beat
    function automatic void predict_updates(logic [1:0] op, logic [1:0] ch, logic [7:0] addr,
                                            logic [7:0] ctl, logic [7:0] br, logic [7:0] dur,
                                            logic [7:0] rate);
        int         f [3];
        int         l [3];
        int         cnt;
        logic [1:0] tgt;
        logic [7:0] lv;
        logic [7:0] nxt;
        bit         extra;
        if (op == OPC_WRITE)
        begin
            pat_mem[addr] = {rate, dur, br, ctl};
        end
        else if (op == OPC_START)
        begin
            f = '{0, 0, 0};
            l = '{0, 0, 0};
            cnt = 0;
            for (int i = 0; i < 256 && cnt < 3; i++)
            begin
                if ((pat_mem[i] & {24'd0, LAST_MARK}) != 0)
                begin
                    l[cnt] = i;
                    cnt++;
                    if (cnt < 3)
                        f[cnt] = i + 1;
                end
            end
            if (cnt < 3)
            begin
                led_updates_q.push_back('{2'd0, 8'd0, 16'd0, 1'b0, 1'b1, 1'b1});
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    first_ix[i] = f[i][7:0];
                    last_ix[i]  = l[i][7:0];
                    cur_ix[i]   = f[i][7:0];
                end
                for (int i = 0; i < 3; i++)
                begin
                    tgt = load_instr(pat_mem[cur_ix[i]]);
                    if (tgt == CH_NONE)
                        led_updates_q.push_back('{CH_NONE, 8'd0, 16'd0, 1'b0, 1'b0, i == 2});
                    else
                        led_updates_q.push_back('{tgt, lvl_r[tgt], per_r[tgt], 1'b1, 1'b0,
                                                  i == 2});
                end
            end
        end
        else if (op == OPC_TICK && ch != CH_NONE)
        begin
            tgt = CH_NONE;
            step_level(ch);
            lv = lvl_r[ch];
            left_r[ch] = left_r[ch] - 16'd1;
            if (left_r[ch] == 16'd0)
            begin
                nxt = (cur_ix[ch] == last_ix[ch]) ? first_ix[ch] : cur_ix[ch] + 8'd1;
                cur_ix[ch] = nxt;
                tgt = load_instr(pat_mem[nxt]);
            end
            extra = (tgt != CH_NONE) && (tgt != ch);
            led_updates_q.push_back('{ch, lv, per_r[ch], tgt == ch, 1'b0, !extra});
            if (extra)
                led_updates_q.push_back('{tgt, lvl_r[tgt], per_r[tgt], 1'b1, 1'b0, 1'b1});
        end
    endfunction

    task automatic report_err(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Drive one beat on the input stream, with a random gap ahead of it
    task automatic send_beat(logic [1:0] op, logic [1:0] ch, logic [7:0] addr, logic [7:0] ctl,
                             logic [7:0] br, logic [7:0] dur, logic [7:0] rate);
        int gap;
        bit hs;
        gap = (!calm && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, rate, dur, br, ctl, addr, ch};
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
    endtask

    task automatic issue(logic [1:0] op, logic [1:0] ch, logic [7:0] addr, logic [7:0] ctl,
                         logic [7:0] br, logic [7:0] dur, logic [7:0] rate);
        send_beat(op, ch, addr, ctl, br, dur, rate);
        predict_updates(op, ch, addr, ctl, br, dur, rate);
    endtask

    // Hold until every update has come out and the back end has drained
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (led_updates_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_spb(logic [15:0] v);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        spb_m = v;
    endtask

    // Write a program at the bottom of the store, add noise, start and tick
    task automatic run_round(output int items);
        int         n;
        int         e0;
        int         e1;
        logic [1:0] ch;
        logic [7:0] ctl;
        logic [7:0] dur;
        logic [7:0] rate;
        logic [7:0] a;
        int         ticks;
        items = 0;
        n  = $urandom_range(3, 8);
        e0 = $urandom_range(0, n - 3);
        e1 = $urandom_range(e0 + 1, n - 2);
        for (int i = 0; i < n; i++)
        begin
            ch  = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
            ctl = {ch, 2'($urandom_range(0, 3)), 3'($urandom), 1'b0};
            if (i == e0 || i == e1 || i == n - 1)
                ctl = ctl | LAST_MARK;
            dur  = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
            rate = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
            issue(OPC_WRITE, 2'($urandom), 8'(i), ctl, 8'($urandom), dur, rate);
            items++;
        end
        repeat ($urandom_range(0, 2))
        begin
            a = 8'($urandom_range(n, 255));
            issue(OPC_WRITE, 2'($urandom), a, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
            items++;
        end
        // broken program: strip every end mark so the start must fail
        if ($urandom_range(0, 7) == 0)
        begin
            for (int i = 0; i < 256; i++)
            begin
                if ((pat_mem[i] & {24'd0, LAST_MARK}) != 0)
                begin
                    issue(OPC_WRITE, 2'd0, 8'(i), pat_mem[i][7:0] & ~LAST_MARK,
                          pat_mem[i][15:8], pat_mem[i][23:16], pat_mem[i][31:24]);
                    items++;
                end
            end
        end
        issue(OPC_START, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
        items++;
        ticks = $urandom_range(15, 40);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                issue(($urandom_range(0, 1) != 0) ? OPC_IGNORED : OPC_TICK, CH_NONE,
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
            begin
                issue(OPC_TICK, 2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
                items++;
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Check each output beat against the oldest expected update
    always @(negedge clk)
    begin
        result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (led_updates_q.size() == 0)
                report_err($sformatf("unexpected beat tdata=%h", m_axis_tdata));
            else
            begin
                e = led_updates_q.pop_front();
                if (m_axis_tdata[1:0] != e.channel)
                    report_err($sformatf("channel %0d exp %0d", m_axis_tdata[1:0], e.channel));
                if (m_axis_tdata[9:2] != e.intensity)
                    report_err($sformatf("ch %0d intensity %0d exp %0d", e.channel,
                                         m_axis_tdata[9:2], e.intensity));
                if (m_axis_tdata[25:10] != e.period)
                    report_err($sformatf("ch %0d period %0d exp %0d", e.channel,
                                         m_axis_tdata[25:10], e.period));
                if (m_axis_tdata[26] != e.reloaded)
                    report_err($sformatf("ch %0d reloaded %0b exp %0b", e.channel,
                                         m_axis_tdata[26], e.reloaded));
                if (m_axis_tuser[0] != e.error)
                    report_err($sformatf("error %0b exp %0b", m_axis_tuser[0], e.error));
                if (m_axis_tlast != e.last)
                    report_err($sformatf("tlast %0b exp %0b", m_axis_tlast, e.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [15:0] spb_list [5];
        int          n0;
        int          done;
        int          got;
        err_cnt = 0;
        cycles  = 0;
        calm    = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            first_ix[c] = 8'd0;
            last_ix[c]  = 8'd0;
            cur_ix[c]   = 8'd0;
            kind_r[c]   = KIND_FLASH;
            peak_r[c]   = 8'd0;
            lvl_r[c]    = 8'd0;
            step_r[c]   = 4'd0;
            rise_r[c]   = 1'b0;
            left_r[c]   = 16'd0;
            per_r[c]    = 16'd0;
        end
        spb_m = SPB_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear the whole store so nothing reads an unwritten entry
        for (int i = 0; i < 256; i++)
            issue(OPC_WRITE, 2'd0, 8'(i), 8'h00, 8'h00, 8'h00, 8'h00);

        // Directed rows at the reset beat period
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].addr, dir_rows[i].ctl,
                      dir_rows[i].br, dir_rows[i].dur, dir_rows[i].rate);
            n0 = led_updates_q.size();
            predict_updates(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].addr, dir_rows[i].ctl,
                            dir_rows[i].br, dir_rows[i].dur, dir_rows[i].rate);
            if (dir_rows[i].fixed)
            begin
                while (led_updates_q.size() > n0)
                    void'(led_updates_q.pop_back());
                led_updates_q.push_back(dir_rows[i].exp);
            end
        end

        // Random rounds across beat period settings, extremes included
        spb_list = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom)};
        foreach (spb_list[p])
        begin
            write_spb(spb_list[p]);
            calm = (p == 2);
            done = 0;
            while (done < 25)
            begin
                run_round(got);
                done += got;
            end
        end
        calm = 1'b0;

        wait_quiet();
        if (led_updates_q.size() != 0)
            report_err("updates left over");
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
